// File: rtl/sound_activated_record_gate_core_defines.svh
// ----------------------------------------------------------------------------
// Sound-activated record gate: assertion macros
// Shared macros for the concurrent checks of the record gate core.
// ----------------------------------------------------------------------------
`ifndef SOUND_ACTIVATED_RECORD_GATE_CORE_DEFINES_SVH
`define SOUND_ACTIVATED_RECORD_GATE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SARG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SARG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sarg_pkg.sv
// ----------------------------------------------------------------------------
// Sound-activated record gate package
// Widths, chunk sizes, register codes, event codes and shared structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sarg_pkg;

  // Chunk sizes (log2 of samples per chunk)
  localparam int LISTEN_CHUNK_LOG2 = 5;
  localparam int RECORD_CHUNK_LOG2 = 6;
  localparam int CHUNK_LOG2_MAX    = (LISTEN_CHUNK_LOG2 > RECORD_CHUNK_LOG2) ?
                                     LISTEN_CHUNK_LOG2 : RECORD_CHUNK_LOG2;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = SAMPLE_W + 1;
  localparam int SUM_W    = SAMPLE_W + CHUNK_LOG2_MAX;
  localparam int POS_W    = CHUNK_LOG2_MAX;
  localparam int LEVEL_W  = 16;
  localparam int CNT_W    = 20;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 3;

  localparam int LISTEN_LEN = 1 << LISTEN_CHUNK_LOG2;
  localparam int RECORD_LEN = 1 << RECORD_CHUNK_LOG2;
  localparam logic [POS_W-1:0] LISTEN_LAST = POS_W'(LISTEN_LEN - 1);
  localparam logic [POS_W-1:0] RECORD_LAST = POS_W'(RECORD_LEN - 1);

  // Register defaults
  localparam logic [LEVEL_W-1:0] TRIGGER_LEVEL_RST = LEVEL_W'(2000);
  localparam logic [LEVEL_W-1:0] KEEP_LEVEL_RST    = LEVEL_W'(1500);
  localparam logic [CNT_W-1:0]   HOLD_SAMPLES_RST  = CNT_W'(40000);
  localparam logic [CNT_W-1:0]   MAX_SAMPLES_RST   = CNT_W'(480000);
  localparam logic [CNT_W-1:0]   MIN_SAVE_RST      = CNT_W'(160000);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_LEVEL    = 3'd0,
    CFG_KEEP_LEVEL       = 3'd1,
    CFG_HOLD_SAMPLES     = 3'd2,
    CFG_MAX_SAMPLES      = 3'd3,
    CFG_MIN_SAVE_SAMPLES = 3'd4
  } cfg_idx_t;

  // Event codes
  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_TRIGGER = 2'd1,
    EVT_QUIET   = 2'd2,
    EVT_FULL    = 2'd3
  } evt_t;

  // Gate mode
  typedef enum logic {
    MODE_LISTEN = 1'b0,
    MODE_RECORD = 1'b1
  } mode_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] trigger_level;
    logic [LEVEL_W-1:0] keep_level;
    logic [CNT_W-1:0]   hold_samples;
    logic [CNT_W-1:0]   max_samples;
    logic [CNT_W-1:0]   min_save_samples;
  } cfg_t;

  typedef struct packed {
    logic               store_sample;
    logic [CNT_W-1:0]   store_address;
    evt_t               event_res;
    logic               save_ok;
    logic [LEVEL_W-1:0] chunk_level;
    logic [CNT_W-1:0]   recorded_length;
  } result_t;

endpackage

// File: rtl/sarg_cfg_regs.sv
// ----------------------------------------------------------------------------
// Record gate configuration registers
// Write-only register bank with reset defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sarg_cfg_regs
  import sarg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TRIGGER_LEVEL:    cfg_nxt.trigger_level    = cfg_wdata[LEVEL_W-1:0];
        CFG_KEEP_LEVEL:       cfg_nxt.keep_level       = cfg_wdata[LEVEL_W-1:0];
        CFG_HOLD_SAMPLES:     cfg_nxt.hold_samples     = cfg_wdata[CNT_W-1:0];
        CFG_MAX_SAMPLES:      cfg_nxt.max_samples      = cfg_wdata[CNT_W-1:0];
        CFG_MIN_SAVE_SAMPLES: cfg_nxt.min_save_samples = cfg_wdata[CNT_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_level    <= TRIGGER_LEVEL_RST;
      cfg_r.keep_level       <= KEEP_LEVEL_RST;
      cfg_r.hold_samples     <= HOLD_SAMPLES_RST;
      cfg_r.max_samples      <= MAX_SAMPLES_RST;
      cfg_r.min_save_samples <= MIN_SAVE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/sarg_in_reg.sv
// ----------------------------------------------------------------------------
// Record gate input register
// Holds one accepted sample request until the gate logic takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sarg_in_reg
  import sarg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       advance,
  output logic                       s1_valid,
  output logic signed [SAMPLE_W-1:0] s1_sample
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       accept;

  // Stall only when the held request cannot move on this cycle
  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
    end
  end

  assign s1_valid  = valid_r;
  assign s1_sample = sample_r;

endmodule

// File: rtl/sarg_gate.sv
// ----------------------------------------------------------------------------
// Record gate decision logic
// Chunk level, trigger, quiet hold and store addressing in one pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sarg_gate
  import sarg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic signed [SAMPLE_W-1:0] s1_sample,
  input  cfg_t                       cfg,
  output result_t                    res
);

  mode_t              mode_r,  mode_nxt;
  logic [SUM_W-1:0]   sum_r,   sum_nxt;
  logic [POS_W-1:0]   pos_r,   pos_nxt;
  logic [CNT_W-1:0]   quiet_r, quiet_nxt;
  logic [CNT_W-1:0]   rec_r,   rec_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;

  logic [MAG_W-1:0]   mag;
  logic [SUM_W-1:0]   sum_add;
  logic [CNT_W-1:0]   quiet_inc;
  logic               room_short;
  evt_t               evt;

  // Magnitude of the sample, 0 .. 32768
  assign mag = s1_sample[SAMPLE_W-1] ?
               (MAG_W'(1 << SAMPLE_W) - {1'b0, s1_sample}) : {1'b0, s1_sample};

  assign sum_add   = sum_r + SUM_W'(mag);
  assign quiet_inc = (quiet_r == {CNT_W{1'b1}}) ? quiet_r : quiet_r + CNT_W'(1);

  // Next state and result
  always_comb begin
    mode_nxt   = mode_r;
    sum_nxt    = sum_add;
    pos_nxt    = pos_r + POS_W'(1);
    quiet_nxt  = quiet_r;
    rec_nxt    = rec_r;
    level_nxt  = level_r;
    room_short = 1'b0;
    evt        = EVT_NONE;
    res        = '0;

    unique case (mode_r)
      MODE_LISTEN: begin
        if (pos_r == LISTEN_LAST) begin
          level_nxt = LEVEL_W'(sum_add >> LISTEN_CHUNK_LOG2);
          sum_nxt   = '0;
          pos_nxt   = '0;
          if (level_nxt >= cfg.trigger_level) begin
            mode_nxt  = MODE_RECORD;
            rec_nxt   = '0;
            quiet_nxt = '0;
            evt       = EVT_TRIGGER;
          end
        end
      end
      MODE_RECORD: begin
        if (rec_r < cfg.max_samples) begin
          res.store_sample  = 1'b1;
          res.store_address = rec_r;
          rec_nxt           = rec_r + CNT_W'(1);
        end
        quiet_nxt = quiet_inc;
        if (pos_r == RECORD_LAST) begin
          level_nxt = LEVEL_W'(sum_add >> RECORD_CHUNK_LOG2);
          sum_nxt   = '0;
          pos_nxt   = '0;
          // Quiet end wins over full store
          if (quiet_inc >= cfg.hold_samples) begin
            evt = EVT_QUIET;
          end else begin
            if (level_nxt >= cfg.keep_level) begin
              quiet_nxt = '0;
            end
            // Store cannot take another full chunk
            room_short = ({1'b0, rec_nxt} + (CNT_W+1)'(RECORD_LEN)) >
                         {1'b0, cfg.max_samples};
            if (room_short) begin
              evt = EVT_FULL;
            end
          end
          if (evt != EVT_NONE) begin
            mode_nxt    = MODE_LISTEN;
            res.save_ok = (rec_nxt >= cfg.min_save_samples);
          end
        end
      end
      default: mode_nxt = MODE_LISTEN;
    endcase

    res.event_res       = evt;
    res.chunk_level     = level_nxt;
    res.recorded_length = rec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_LISTEN;
      sum_r   <= '0;
      pos_r   <= '0;
      quiet_r <= '0;
      rec_r   <= '0;
      level_r <= '0;
    end else if (advance) begin
      mode_r  <= mode_nxt;
      sum_r   <= sum_nxt;
      pos_r   <= pos_nxt;
      quiet_r <= quiet_nxt;
      rec_r   <= rec_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

// File: rtl/sarg_out_reg.sv
// ----------------------------------------------------------------------------
// Record gate result register
// Holds one result request until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sarg_out_reg
  import sarg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t out_res
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// File: rtl/sound_activated_record_gate_core.sv
// ----------------------------------------------------------------------------
// Sound-activated record gate core
// Path: a sample request is taken into the input register and moves on to the
// result register once that register is free or draining; out_stall holds it.
// Throughput: one sample per cycle; only a held, stalled result stalls input.
// Reset (synchronous, rst_n low): listening, all counters and sums zero,
// registers at their defaults; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sound_activated_record_gate_core_defines.svh"

module sound_activated_record_gate_core
  import sarg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata,
  // sample requests
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  // results
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_store_sample,
  output logic [CNT_W-1:0]           out_store_address,
  output logic [1:0]                 out_event_res,
  output logic                       out_save_ok,
  output logic [LEVEL_W-1:0]         out_chunk_level,
  output logic [CNT_W-1:0]           out_recorded_length
);

  cfg_t                       cfg;
  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic                       advance;
  result_t                    gate_res;
  result_t                    out_res;

  // Move the held sample on whenever the result register is free or draining
  assign advance = s1_valid && (!out_valid || !out_stall);

  sarg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sarg_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_sample (s1_sample)
  );

  sarg_gate u_gate (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .s1_sample (s1_sample),
    .cfg       (cfg),
    .res       (gate_res)
  );

  sarg_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (gate_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_store_sample    = out_res.store_sample;
  assign out_store_address   = out_res.store_address;
  assign out_event_res       = out_res.event_res;
  assign out_save_ok         = out_res.save_ok;
  assign out_chunk_level     = out_res.chunk_level;
  assign out_recorded_length = out_res.recorded_length;

  // Checks
  `SARG_ASSERT_NOW(a_trigger_not_stored, out_valid && out_store_sample, out_event_res != EVT_TRIGGER, "triggering sample was stored")
  `SARG_ASSERT_NOW(a_length_follows_addr, out_valid && out_store_sample, out_recorded_length == (out_store_address + CNT_W'(1)), "length does not follow store address")
  `SARG_ASSERT_NOW(a_save_only_at_end, out_valid && out_save_ok, (out_event_res == EVT_QUIET) || (out_event_res == EVT_FULL), "save flag outside an end event")
  `SARG_ASSERT_NOW(a_stall_only_when_full, in_stall, s1_valid && out_valid && out_stall, "input stalled while the pipe can move")
  `SARG_ASSERT_NEXT(a_advance_loads_result, advance, out_valid, "advanced request gave no result")

endmodule

// File: dv/sound_activated_record_gate_core_test.sv
// ----------------------------------------------------------------------------
// Sound-activated record gate core: testbench
// Sends mono sample requests through the valid/stall channel and checks every
// result against a cycle-free model of the listen/record gate. A short
// directed plan hits the extremes and the corner cases of the gate. Random
// phases follow, each with its own register setting and one of four idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sound_activated_record_gate_core_test;
  import sarg_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 200;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 80;
  localparam int MAX_PRINTS    = 50;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;
  typedef enum logic [1:0] {SEG_LOUD, SEG_QUIET, SEG_NOISE} seg_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    cfg_idx_t         reg_idx;
    logic [CFG_W-1:0] value;
    int unsigned      reps;
    bit               typed;
    result_t          want;
  } plan_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_wdata;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_stall;
  logic                       out_store_sample;
  logic [CNT_W-1:0]           out_store_address;
  logic [1:0]                 out_event_res;
  logic                       out_save_ok;
  logic [LEVEL_W-1:0]         out_chunk_level;
  logic [CNT_W-1:0]           out_recorded_length;

  // Gate model state and register copy
  cfg_t               gate_cfg;
  mode_t              gate_mode;
  logic [SUM_W-1:0]   mag_sum;
  int unsigned        chunk_pos;
  logic [CNT_W-1:0]   quiet_cnt;
  logic [CNT_W-1:0]   rec_len;
  logic [LEVEL_W-1:0] last_lvl;

  result_t     gate_results[$];
  plan_row_t   dir_plan[$];
  int unsigned cycle_cnt      = 0;
  int          mismatches     = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_requests  = 0;
  int          holds_served   = 0;
  int          hold_left      = 0;

  sound_activated_record_gate_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_store_sample    (out_store_sample),
    .out_store_address   (out_store_address),
    .out_event_res       (out_event_res),
    .out_save_ok         (out_save_ok),
    .out_chunk_level     (out_chunk_level),
    .out_recorded_length (out_recorded_length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One sample through the gate: works out the result and moves the state on
  function automatic result_t predict_gate(logic [SAMPLE_W-1:0] s);
    logic [MAG_W-1:0] mag;
    result_t r;
    r = '0;
    mag = s[SAMPLE_W-1] ? (MAG_W'(1 << SAMPLE_W) - {1'b0, s}) : {1'b0, s};
    if (gate_mode == MODE_LISTEN) begin
      mag_sum = mag_sum + SUM_W'(mag);
      chunk_pos++;
      if (chunk_pos >= LISTEN_LEN) begin
        last_lvl  = LEVEL_W'(mag_sum >> LISTEN_CHUNK_LOG2);
        mag_sum   = '0;
        chunk_pos = 0;
        if (last_lvl >= gate_cfg.trigger_level) begin
          gate_mode   = MODE_RECORD;
          rec_len     = '0;
          quiet_cnt   = '0;
          r.event_res = EVT_TRIGGER;
        end
      end
    end else begin
      if (rec_len < gate_cfg.max_samples) begin
        r.store_sample  = 1'b1;
        r.store_address = rec_len;
        rec_len         = rec_len + CNT_W'(1);
      end
      if (quiet_cnt != CNT_SAT) quiet_cnt = quiet_cnt + CNT_W'(1);
      mag_sum = mag_sum + SUM_W'(mag);
      chunk_pos++;
      if (chunk_pos >= RECORD_LEN) begin
        last_lvl  = LEVEL_W'(mag_sum >> RECORD_CHUNK_LOG2);
        mag_sum   = '0;
        chunk_pos = 0;
        // quiet wins over full
        if (quiet_cnt >= gate_cfg.hold_samples) begin
          r.event_res = EVT_QUIET;
        end else begin
          if (last_lvl >= gate_cfg.keep_level) quiet_cnt = '0;
          if (rec_len >= gate_cfg.max_samples ||
              (gate_cfg.max_samples - rec_len) < RECORD_LEN)
            r.event_res = EVT_FULL;
        end
        if (r.event_res != EVT_NONE) begin
          gate_mode = MODE_LISTEN;
          r.save_ok = (rec_len >= gate_cfg.min_save_samples);
        end
      end
    end
    r.chunk_level     = last_lvl;
    r.recorded_length = rec_len;
    return r;
  endfunction

  function automatic result_t mk_res(logic st, logic [CNT_W-1:0] addr, evt_t ev, logic sv,
                                     logic [LEVEL_W-1:0] lvl, logic [CNT_W-1:0] len);
    result_t r;
    r.store_sample    = st;
    r.store_address   = addr;
    r.event_res       = ev;
    r.save_ok         = sv;
    r.chunk_level     = lvl;
    r.recorded_length = len;
    return r;
  endfunction

  function automatic void plan_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    plan_row_t row;
    row         = '0;
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.value   = val;
    row.reps    = 1;
    dir_plan.push_back(row);
  endfunction

  // typed: the last sample of the row is checked against want
  function automatic void plan_samples(logic [SAMPLE_W-1:0] val, int unsigned reps, bit typed,
                                       result_t want);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_SAMPLE;
    row.value = CFG_W'(val);
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    dir_plan.push_back(row);
  endfunction

  // Random sample of the given loudness, scaled to the current levels
  function automatic logic [SAMPLE_W-1:0] pick_sample(seg_kind_t seg);
    int unsigned hi_lvl;
    int unsigned lo_lvl;
    int unsigned m;
    logic [SAMPLE_W-1:0] v;
    hi_lvl = 32'((gate_cfg.trigger_level > gate_cfg.keep_level) ?
                 gate_cfg.trigger_level : gate_cfg.keep_level);
    if (hi_lvl > 32768) hi_lvl = 32768;
    lo_lvl = 32'((gate_cfg.trigger_level < gate_cfg.keep_level) ?
                 gate_cfg.trigger_level : gate_cfg.keep_level) / 2;
    v = SAMPLE_W'($urandom);
    if (seg != SEG_NOISE) begin
      m = (seg == SEG_LOUD) ? $urandom_range(32768, hi_lvl) : $urandom_range(lo_lvl, 0);
      v = m[SAMPLE_W-1:0];
      if (m != 32768 && $urandom_range(1) == 1) v = -v;
    end
    return v;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Register write at a falling edge; the block must be idle
  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      CFG_TRIGGER_LEVEL:    gate_cfg.trigger_level    = val[LEVEL_W-1:0];
      CFG_KEEP_LEVEL:       gate_cfg.keep_level       = val[LEVEL_W-1:0];
      CFG_HOLD_SAMPLES:     gate_cfg.hold_samples     = val[CNT_W-1:0];
      CFG_MAX_SAMPLES:      gate_cfg.max_samples      = val[CNT_W-1:0];
      CFG_MIN_SAVE_SAMPLES: gate_cfg.min_save_samples = val[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Stop sending and wait until every outstanding result is back
  task automatic drain_gate();
    in_valid = 1'b0;
    while (gate_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Offer one sample request; called and returns at a falling edge
  task automatic send_sample(logic [SAMPLE_W-1:0] s, bit typed, result_t want);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    in_sample = s;
    do @(posedge clk); while (in_stall !== 1'b0);
    r = predict_gate(s);
    gate_results.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Result checker and run limit
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** sound_activated_record_gate_core: FAILED **");
      $finish;
    end else if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.store_sample    = out_store_sample;
      got.store_address   = out_store_address;
      got.event_res       = evt_t'(out_event_res);
      got.save_ok         = out_save_ok;
      got.chunk_level     = out_chunk_level;
      got.recorded_length = out_recorded_length;
      if (gate_results.size() == 0) begin
        report_mismatch($sformatf("result %h with no request outstanding", got));
      end else begin
        want = gate_results.pop_front();
        if (got.store_sample !== want.store_sample)
          report_mismatch($sformatf("store_sample %0d, expected %0d",
                                    got.store_sample, want.store_sample));
        if (got.store_address !== want.store_address)
          report_mismatch($sformatf("store_address %0d, expected %0d",
                                    got.store_address, want.store_address));
        if (got.event_res !== want.event_res)
          report_mismatch($sformatf("event_res %0d, expected %0d",
                                    got.event_res, want.event_res));
        if (got.save_ok !== want.save_ok)
          report_mismatch($sformatf("save_ok %0d, expected %0d", got.save_ok, want.save_ok));
        if (got.chunk_level !== want.chunk_level)
          report_mismatch($sformatf("chunk_level %0d, expected %0d",
                                    got.chunk_level, want.chunk_level));
        if (got.recorded_length !== want.recorded_length)
          report_mismatch($sformatf("recorded_length %0d, expected %0d",
                                    got.recorded_length, want.recorded_length));
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    seg_kind_t        seg;
    int               seg_left;
    int unsigned      pick;
    logic [CFG_W-1:0] trig;
    logic [CFG_W-1:0] keep;
    logic [CFG_W-1:0] hold;
    logic [CFG_W-1:0] maxs;
    logic [CFG_W-1:0] mins;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_TRIGGER_LEVEL;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_sample = '0;

    gate_cfg.trigger_level    = TRIGGER_LEVEL_RST;
    gate_cfg.keep_level       = KEEP_LEVEL_RST;
    gate_cfg.hold_samples     = HOLD_SAMPLES_RST;
    gate_cfg.max_samples      = MAX_SAMPLES_RST;
    gate_cfg.min_save_samples = MIN_SAVE_RST;
    gate_mode = MODE_LISTEN;
    mag_sum   = '0;
    chunk_pos = 0;
    quiet_cnt = '0;
    rec_len   = '0;
    last_lvl  = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Silence after reset: nothing happens, chunk level stays zero
    plan_samples(16'h0000, 31, 1'b1, '0);
    plan_samples(16'h0000, 1, 1'b1, '0);
    // Hold time zero: the first recording chunk ends it
    plan_reg(CFG_HOLD_SAMPLES, 20'h00000);
    plan_reg(CFG_MAX_SAMPLES, 20'hFFFFF);
    plan_reg(CFG_MIN_SAVE_SAMPLES, 20'h00000);
    plan_samples(16'h8000, 32, 1'b1, mk_res(1'b0, 20'd0, EVT_TRIGGER, 1'b0, 16'd32768, 20'd0));
    plan_samples(16'h7FFF, 1, 1'b1, mk_res(1'b1, 20'd0, EVT_NONE, 1'b0, 16'd32768, 20'd1));
    plan_samples(16'h7FFF, 62, 1'b0, '0);
    plan_samples(16'h7FFF, 1, 1'b1, mk_res(1'b1, 20'd63, EVT_QUIET, 1'b1, 16'd32767, 20'd64));
    // Length kept after the end
    plan_samples(16'h0000, 1, 1'b1, mk_res(1'b0, 20'd0, EVT_NONE, 1'b0, 16'd32767, 20'd64));
    plan_samples(16'h0000, 31, 1'b0, '0);
    // Trigger level above full scale is never reached
    plan_reg(CFG_TRIGGER_LEVEL, 20'h0FFFF);
    plan_samples(16'h8000, 32, 1'b1, mk_res(1'b0, 20'd0, EVT_NONE, 1'b0, 16'd32768, 20'd64));
    // Store smaller than a chunk: ends as full, too short to save
    plan_reg(CFG_TRIGGER_LEVEL, 20'h08000);
    plan_reg(CFG_HOLD_SAMPLES, 20'hFFFFF);
    plan_reg(CFG_MAX_SAMPLES, 20'd10);
    plan_reg(CFG_MIN_SAVE_SAMPLES, 20'd11);
    plan_reg(CFG_KEEP_LEVEL, 20'h00000);
    plan_samples(16'h8000, 32, 1'b1, mk_res(1'b0, 20'd0, EVT_TRIGGER, 1'b0, 16'd32768, 20'd0));
    plan_samples(16'h0001, 10, 1'b0, '0);
    plan_samples(16'h0001, 1, 1'b1, mk_res(1'b0, 20'd0, EVT_NONE, 1'b0, 16'd32768, 20'd10));
    plan_samples(16'hFFFF, 52, 1'b0, '0);
    plan_samples(16'hFFFF, 1, 1'b1, mk_res(1'b0, 20'd0, EVT_FULL, 1'b0, 16'd1, 20'd10));
    // Quiet and full at once: quiet wins
    plan_reg(CFG_HOLD_SAMPLES, 20'd64);
    plan_reg(CFG_MIN_SAVE_SAMPLES, 20'd10);
    plan_samples(16'h8000, 32, 1'b0, '0);
    plan_samples(16'h0005, 63, 1'b0, '0);
    plan_samples(16'h0005, 1, 1'b1, mk_res(1'b0, 20'd0, EVT_QUIET, 1'b1, 16'd5, 20'd10));

    foreach (dir_plan[i]) begin
      if (dir_plan[i].kind == ROW_REG) begin
        drain_gate();
        write_reg(dir_plan[i].reg_idx, dir_plan[i].value);
      end else begin
        for (int n = 0; n < dir_plan[i].reps; n++)
          send_sample(dir_plan[i].value[SAMPLE_W-1:0],
                      dir_plan[i].typed && (n == dir_plan[i].reps - 1), dir_plan[i].want);
      end
    end

    // Random phases: loud bursts to trigger and keep recording, quiet gaps, noise
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_gate();
      case (ph)
        0: begin
          trig = '0;
          keep = '0;
          hold = '0;
          maxs = '0;
          mins = '0;
        end
        1: begin
          trig = 20'h08000;
          keep = 20'h08000;
          hold = 20'hFFFFF;
          maxs = 20'hFFFFF;
          mins = 20'hFFFFF;
        end
        default: begin
          trig = CFG_W'($urandom_range(20000, 100));
          keep = CFG_W'($urandom_range(20000, 0));
          hold = CFG_W'($urandom_range(256, 0));
          maxs = CFG_W'(($urandom_range(3) == 0) ? $urandom_range(70, 0) :
                                                   $urandom_range(400, 64));
          mins = CFG_W'($urandom_range(400, 0));
        end
      endcase
      write_reg(CFG_TRIGGER_LEVEL, trig);
      write_reg(CFG_KEEP_LEVEL, keep);
      write_reg(CFG_HOLD_SAMPLES, hold);
      write_reg(CFG_MAX_SAMPLES, maxs);
      write_reg(CFG_MIN_SAVE_SAMPLES, mins);

      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 78;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 78;
        end
        default: begin
          send_idle_pct  = 6;
          recv_stall_pct = 6;
        end
      endcase
      // long receiver hold-off while requests keep coming
      if (ph == 4) hold_requests++;

      seg_left = 0;
      seg      = SEG_QUIET;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (seg_left == 0) begin
          pick     = $urandom_range(99);
          seg      = (pick < 45) ? SEG_LOUD : (pick < 80) ? SEG_QUIET : SEG_NOISE;
          seg_left = $urandom_range(100, 1);
        end
        seg_left--;
        send_sample(pick_sample(seg), 1'b0, '0);
      end
    end

    drain_gate();
    if (mismatches == 0)
      $display("** sound_activated_record_gate_core: PASSED **");
    else
      $display("** sound_activated_record_gate_core: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sarg_pkg.sv
rtl/sarg_cfg_regs.sv
rtl/sarg_in_reg.sv
rtl/sarg_gate.sv
rtl/sarg_out_reg.sv
rtl/sound_activated_record_gate_core.sv
dv/sound_activated_record_gate_core_test.sv
